>>> rtl/core/sbd_pkg.sv
// Shared constants, item types and sequencer codes for the subband energy beat detector.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package sbd_pkg;

    // Block dimensions
    localparam int BAND_COUNT    = 39;
    localparam int BINS_PER_BAND = 5;
    localparam int HISTORY_DEPTH = 64;

    // Field and datapath widths
    localparam int BIN_VALUE_W = 16;
    localparam int MASK_W      = 39;
    localparam int CFG_W       = 16;
    localparam int MAG_W       = 16;
    localparam int ACC_W       = 48;
    localparam int E_W         = 46;
    localparam int SUM_W       = E_W + $clog2(HISTORY_DEPTH);
    localparam int SQ_W        = 2 * E_W + $clog2(HISTORY_DEPTH);
    localparam int WM_W        = 2 * E_W;
    localparam int CNT_W       = $clog2(HISTORY_DEPTH + 1);
    localparam int Q_W         = SQ_W + CNT_W;
    localparam int K_W         = CFG_W + 2 * CNT_W;
    localparam int P_W         = K_W + WM_W;
    localparam int R1_W        = P_W + SUM_W;
    localparam int FM_W        = CFG_W + E_W;
    localparam int EN_W        = 64;

    // Limb multiplier geometry
    localparam int LIMB_W  = 32;
    localparam int A_LIMBS = 6;
    localparam int B_LIMBS = 2;
    localparam int RW      = A_LIMBS * LIMB_W;
    localparam int BW      = B_LIMBS * LIMB_W;

    // Counters and addresses
    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int BAND_W  = $clog2(BAND_COUNT + 1);
    localparam int BIDX_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int BIN_W   = $clog2(BINS_PER_BAND + 1);
    localparam int ADDR_W  = $clog2(BAND_COUNT * HISTORY_DEPTH);
    localparam int PADDR_W = 4;

    localparam int        N_SQ   = HISTORY_DEPTH * HISTORY_DEPTH;
    localparam logic [BW-1:0] N_CUBE = BW'(HISTORY_DEPTH * HISTORY_DEPTH * HISTORY_DEPTH);

    // Band energy = (sum * DIV_RECIP) >> DIV_SHIFT, exact for any 48-bit sum
    localparam int DIV_SHIFT = ACC_W + $clog2(BINS_PER_BAND);
    localparam logic [BW-1:0] DIV_RECIP =
        BW'(((64'd1 << DIV_SHIFT) + 64'(BINS_PER_BAND - 1)) / 64'(BINS_PER_BAND));

    // Register map (index = byte address / 4)
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;
    localparam logic [1:0] REG_FLOOR  = 2'd3;

    localparam logic [CFG_W-1:0] GAIN_RST   = 16'd61440;
    localparam logic [CFG_W-1:0] OFFSET_RST = 16'd5734;
    localparam logic [CFG_W-1:0] SCALE_RST  = 16'd3562;
    localparam logic [CFG_W-1:0] FLOOR_RST  = 16'd614;

    typedef struct packed {
        logic signed [BIN_VALUE_W-1:0] bin_value;
        logic                          last_bin;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] beat_mask;
        logic              history_ready;
    } t_out_item;

    // Request to the limb multiplier
    typedef struct packed {
        logic       start;
        logic       accum;
        logic [2:0] a_last;
        logic       b_last;
    } t_mul_req;

    // Multiply steps of the beat test
    typedef enum logic [3:0] {
        OP_WM = 4'd0,
        OP_NS = 4'd1,
        OP_SS = 4'd2,
        OP_P  = 4'd3,
        OP_NQ = 4'd4,
        OP_EN = 4'd5,
        OP_L  = 4'd6,
        OP_R1 = 4'd7,
        OP_R2 = 4'd8
    } t_op;

endpackage

`default_nettype wire

>>> rtl/core/subband_energy_beat_detector.sv
// Top level of the subband energy beat detector: bin intake, band division, history RAM
// and the beat-test sequencer. Depends on sbd_pkg and sbd_mulacc.
//
//  channel   direction  handshake                 payload
//  in        to block   i_in_valid / o_in_stall   i_in_data  (t_in_item, one FFT bin)
//  out       from block o_out_valid / i_out_stall o_out_data (t_out_item, one per chunk)
//  config    to block   APB psel/penable/pwrite   paddr, pwdata, prdata (4 x 16-bit regs)
//
//  A bin passes through accept, square, cube and bookkeeping steps; closing a band adds
//  the reciprocal multiply by 1/BINS_PER_BAND in the limb multiplier. Once history is
//  full, each band test walks its 64 history words through the 32x32 limb multiplier
//  and then runs up to 9 wide multiplies; the shared limb multiplier sets the pace.
//  Reset leaves the history RAM unwritten; the first 64 chunks fill it before any test.
//  A result stalled at the output holds; the next chunk's bins are still taken meanwhile.
`default_nettype none

module subband_energy_beat_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  sbd_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output sbd_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sbd_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000000000000001,
        S_SQ    = 16'b0000000000000010,
        S_CUBE  = 16'b0000000000000100,
        S_NEXT  = 16'b0000000000001000,
        S_DIV   = 16'b0000000000010000,
        S_CLOSE = 16'b0000000000100000,
        S_RD    = 16'b0000000001000000,
        S_ACC   = 16'b0000000010000000,
        S_SQW   = 16'b0000000100000000,
        S_T0    = 16'b0000001000000000,
        S_T1    = 16'b0000010000000000,
        S_MUL   = 16'b0000100000000000,
        S_MULW  = 16'b0001000000000000,
        S_WR    = 16'b0010000000000000,
        S_EMIT  = 16'b0100000000000000,
        S_DIVW  = 16'b1000000000000000
    } t_state;

    t_state r_state;
    t_op    r_op;

    // configuration
    logic [CFG_W-1:0] r_gain, r_offs, r_scale, r_floor;

    // chunk and band bookkeeping
    logic [ACC_W-1:0]      r_acc;
    logic [BIN_W-1:0]      r_bin;
    logic [BAND_W-1:0]     r_band;
    logic [SLOT_W-1:0]     r_slot;
    logic [CNT_W-1:0]      r_filled;
    logic [BAND_COUNT-1:0] r_mask;
    logic                  r_flush;
    logic [MAG_W-1:0]      r_mag;
    logic [2*MAG_W-1:0]    r_m2;

    // band sum waiting for division by BINS_PER_BAND
    logic [ACC_W-1:0]  r_div;

    // beat test operands
    logic [E_W-1:0]   r_e;
    logic [SLOT_W-1:0] r_j;
    logic [E_W-1:0]   r_m;
    logic [SUM_W-1:0] r_s;
    logic [SQ_W-1:0]  r_sq;
    logic [K_W-1:0]   r_k;
    logic [FM_W-1:0]  r_fm;
    logic [WM_W-1:0]  r_wm;
    logic [Q_W-1:0]   r_q;
    logic [P_W-1:0]   r_p;
    logic [P_W-1:0]   r_d;
    logic [EN_W-1:0]  r_en;
    logic [RW-1:0]    r_lhs;
    logic [R1_W-1:0]  r_r1;
    logic             r_flag;

    // output register
    logic              r_ovalid;
    logic [MASK_W-1:0] r_omask;
    logic              r_oready;

    // history RAM
    logic [E_W-1:0]    mem [BAND_COUNT * HISTORY_DEPTH];
    logic [E_W-1:0]    r_rdata;
    logic [ADDR_W-1:0] mem_addr;
    logic [SLOT_W-1:0] slot_sel;

    // multiplier
    t_mul_req         mul_req;
    logic [RW-1:0]    mul_a;
    logic [BW-1:0]    mul_b;
    logic             mul_busy;
    logic [RW-1:0]    mul_acc;

    // combinational helpers
    logic [MAG_W-1:0]   in_mag;
    logic [ACC_W-1:0]   cube;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_sat;
    logic [BIN_W-1:0]   bin_inc;
    logic               e_nz;
    logic               hist_full;
    logic               cfg_wr;

    sbd_mulacc u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_acc   (mul_acc)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_offs  <= OFFSET_RST;
            r_scale <= SCALE_RST;
            r_floor <= FLOOR_RST;
        end else if (cfg_wr) begin
            case (paddr[PADDR_W-1:2])
                REG_GAIN:   r_gain  <= pwdata[CFG_W-1:0];
                REG_OFFSET: r_offs  <= pwdata[CFG_W-1:0];
                REG_SCALE:  r_scale <= pwdata[CFG_W-1:0];
                REG_FLOOR:  r_floor <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1:2])
            REG_GAIN:   prdata = 32'(r_gain);
            REG_OFFSET: prdata = 32'(r_offs);
            REG_SCALE:  prdata = 32'(r_scale);
            REG_FLOOR:  prdata = 32'(r_floor);
            default:    prdata = 32'd0;
        endcase
    end

    // bin magnitude, cube and saturating accumulate
    assign in_mag  = i_in_data.bin_value[BIN_VALUE_W-1]
                   ? MAG_W'(-i_in_data.bin_value) : MAG_W'(i_in_data.bin_value);
    assign cube    = ACC_W'(r_m2) * ACC_W'(r_mag);
    assign acc_sum = {1'b0, r_acc} + {1'b0, cube};
    assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    assign bin_inc = r_bin + BIN_W'(1);

    assign e_nz      = (r_e != '0);
    assign hist_full = (r_filled >= CNT_W'(HISTORY_DEPTH));

    // history RAM, band-major
    assign slot_sel = (r_state == S_RD) ? r_j : r_slot;
    assign mem_addr = ADDR_W'(r_band) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(slot_sel);

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            mem[mem_addr] <= r_e;
        end
        if (r_state == S_RD) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // multiplier requests
    always_comb begin
        mul_req = '0;
        mul_a   = '0;
        mul_b   = '0;
        if (r_state == S_DIV) begin
            // band sum times the reciprocal of BINS_PER_BAND
            mul_req.start  = 1'b1;
            mul_req.a_last = 3'((ACC_W + LIMB_W - 1) / LIMB_W - 1);
            mul_req.b_last = 1'b1;
            mul_a          = RW'(r_div);
            mul_b          = DIV_RECIP;
        end else if (r_state == S_ACC) begin
            mul_req.start  = 1'b1;
            mul_req.accum  = (r_j != '0);
            mul_req.a_last = 3'((E_W + LIMB_W - 1) / LIMB_W - 1);
            mul_req.b_last = 1'b1;
            mul_a          = RW'(r_rdata);
            mul_b          = BW'(r_rdata);
        end else if (r_state == S_MUL) begin
            mul_req.start = 1'b1;
            case (r_op)
                OP_WM: begin
                    mul_req.a_last = 3'((E_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_req.b_last = 1'b1;
                    mul_a = RW'(r_m);
                    mul_b = BW'(r_m);
                end
                OP_NS: begin
                    mul_req.a_last = 3'((SQ_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_a = RW'(r_sq);
                    mul_b = BW'(HISTORY_DEPTH);
                end
                OP_SS: begin
                    mul_req.a_last = 3'((SUM_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_req.b_last = 1'b1;
                    mul_a = RW'(r_s);
                    mul_b = BW'(r_s);
                end
                OP_P: begin
                    mul_req.a_last = 3'((WM_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_a = RW'(r_wm);
                    mul_b = BW'(r_k);
                end
                OP_NQ: begin
                    mul_req.a_last = 3'((Q_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_a = RW'(r_q);
                    mul_b = BW'(r_gain);
                end
                OP_EN: begin
                    mul_req.a_last = 3'((E_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_a = RW'(r_e);
                    mul_b = N_CUBE;
                end
                OP_L: begin
                    mul_req.a_last = 3'((WM_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_req.b_last = 1'b1;
                    mul_a = RW'(r_wm);
                    mul_b = r_en;
                end
                OP_R1: begin
                    mul_req.a_last = 3'((P_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_req.b_last = 1'b1;
                    mul_a = RW'(r_d);
                    mul_b = BW'(r_s);
                end
                OP_R2: begin
                    mul_req.a_last = 3'((R1_W + LIMB_W - 1) / LIMB_W - 1);
                    mul_a = RW'(r_r1);
                    mul_b = BW'(r_scale);
                end
                default: mul_req.start = 1'b0;
            endcase
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_WM;
            r_acc    <= '0;
            r_bin    <= '0;
            r_band   <= '0;
            r_slot   <= '0;
            r_filled <= '0;
            r_mask   <= '0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // S_EMIT reloads the output register itself
            if (r_ovalid && !i_out_stall && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_flush <= i_in_data.last_bin;
                        r_mag   <= in_mag;
                        r_state <= (r_band < BAND_W'(BAND_COUNT)) ? S_SQ : S_NEXT;
                    end
                end
                S_SQ: begin
                    r_m2    <= r_mag * r_mag;
                    r_state <= S_CUBE;
                end
                S_CUBE: begin
                    if (bin_inc >= BIN_W'(BINS_PER_BAND)) begin
                        r_div   <= acc_sat;
                        r_acc   <= '0;
                        r_bin   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_acc   <= acc_sat;
                        r_bin   <= bin_inc;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (!r_flush) begin
                        r_state <= S_IDLE;
                    end else if (r_band < BAND_W'(BAND_COUNT)) begin
                        if (r_bin != '0) begin
                            // partial band at chunk end
                            r_div   <= r_acc;
                            r_acc   <= '0;
                            r_bin   <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_e     <= '0;
                            r_state <= S_CLOSE;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (!mul_busy) begin
                        r_e     <= mul_acc[DIV_SHIFT +: E_W];
                        r_state <= S_CLOSE;
                    end
                end
                S_CLOSE: begin
                    if (hist_full) begin
                        r_j     <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_flag  <= 1'b0;
                        r_state <= S_WR;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // max and sum here, square goes to the multiplier
                    if (r_j == '0) begin
                        r_m <= r_rdata;
                        r_s <= SUM_W'(r_rdata);
                    end else begin
                        if (r_rdata > r_m) begin
                            r_m <= r_rdata;
                        end
                        r_s <= r_s + SUM_W'(r_rdata);
                    end
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    if (!mul_busy) begin
                        if (r_j == SLOT_W'(HISTORY_DEPTH - 1)) begin
                            r_state <= S_T0;
                        end else begin
                            r_j     <= r_j + SLOT_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_T0: begin
                    r_sq <= mul_acc[SQ_W-1:0];
                    r_k  <= K_W'(r_offs) * K_W'(N_SQ);
                    r_fm <= FM_W'(r_floor) * FM_W'(r_m);
                    if (r_m == '0) begin
                        r_flag  <= e_nz;
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    if (FM_W'({r_e, 12'b0}) > r_fm) begin
                        r_flag  <= 1'b1;
                        r_state <= S_WR;
                    end else begin
                        r_op    <= OP_WM;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    if (!mul_busy) begin
                        r_state <= S_MUL;
                        case (r_op)
                            OP_WM: begin
                                r_wm <= mul_acc[WM_W-1:0];
                                r_op <= OP_NS;
                            end
                            OP_NS: begin
                                r_q  <= mul_acc[Q_W-1:0];
                                r_op <= OP_SS;
                            end
                            OP_SS: begin
                                r_q  <= r_q - mul_acc[Q_W-1:0];
                                r_op <= OP_P;
                            end
                            OP_P: begin
                                r_p  <= mul_acc[P_W-1:0];
                                r_op <= OP_NQ;
                            end
                            OP_NQ: begin
                                // negative or zero threshold factor decides at once
                                if (RW'(r_p) < mul_acc) begin
                                    r_flag  <= (r_scale != '0) || e_nz;
                                    r_state <= S_WR;
                                end else if (RW'(r_p) == mul_acc) begin
                                    r_flag  <= e_nz;
                                    r_state <= S_WR;
                                end else begin
                                    r_d  <= r_p - mul_acc[P_W-1:0];
                                    r_op <= OP_EN;
                                end
                            end
                            OP_EN: begin
                                r_en <= mul_acc[EN_W-1:0];
                                r_op <= OP_L;
                            end
                            OP_L: begin
                                r_lhs <= mul_acc << 24;
                                r_op  <= OP_R1;
                            end
                            OP_R1: begin
                                r_r1 <= mul_acc[R1_W-1:0];
                                r_op <= OP_R2;
                            end
                            OP_R2: begin
                                r_flag  <= (r_lhs > mul_acc);
                                r_state <= S_WR;
                            end
                            default: r_state <= S_WR;
                        endcase
                    end
                end
                S_WR: begin
                    // RAM write of the new energy happens in the RAM block
                    if (r_flag) begin
                        r_mask[r_band[BIDX_W-1:0]] <= 1'b1;
                    end
                    r_band  <= r_band + BAND_W'(1);
                    r_state <= S_NEXT;
                end
                S_EMIT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_omask  <= hist_full ? MASK_W'(r_mask) : '0;
                        r_oready <= hist_full;
                        r_slot   <= (r_slot == SLOT_W'(HISTORY_DEPTH - 1))
                                  ? '0 : r_slot + SLOT_W'(1);
                        if (!hist_full) begin
                            r_filled <= r_filled + CNT_W'(1);
                        end
                        r_acc   <= '0;
                        r_bin   <= '0;
                        r_band  <= '0;
                        r_mask  <= '0;
                        r_flush <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall               = (r_state != S_IDLE);
    assign o_out_valid              = r_ovalid;
    assign o_out_data.beat_mask     = r_omask;
    assign o_out_data.history_ready = r_oready;

endmodule

`default_nettype wire

>>> rtl/core/sbd_mulacc.sv
// Limb-serial multiply-accumulate: one 32x32 partial product per cycle, added to the accumulator in the next cycle.
// Depends on sbd_pkg.
`default_nettype none

module sbd_mulacc (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sbd_pkg::t_mul_req      i_req,
    input  logic [sbd_pkg::RW-1:0] i_a,
    input  logic [sbd_pkg::BW-1:0] i_b,
    output logic                   o_busy,
    output logic [sbd_pkg::RW-1:0] o_acc
);
    import sbd_pkg::*;

    logic [A_LIMBS-1:0][LIMB_W-1:0] r_a;
    logic [B_LIMBS-1:0][LIMB_W-1:0] r_b;
    logic [2:0]                     r_a_last;
    logic                           r_b_last;
    logic [2:0]                     r_i;
    logic                           r_j;
    logic                           r_run;
    logic                           r_pv;
    logic [2*LIMB_W-1:0]            r_pp;
    logic [2:0]                     r_sh;
    logic [RW-1:0]                  r_acc;
    logic [RW-1:0]                  pp_shifted;

    // place the partial product at its limb offset
    assign pp_shifted = RW'(r_pp) << {r_sh, 5'b0};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pv  <= 1'b0;
        end else begin
            r_pv <= r_run;
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_i == r_a_last && r_j == r_b_last) begin
                r_run <= 1'b0;
            end
        end
    end

    // operands, limb walk and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_a_last <= i_req.a_last;
            r_b_last <= i_req.b_last;
            r_i      <= 3'd0;
            r_j      <= 1'b0;
            if (!i_req.accum) begin
                r_acc <= '0;
            end
        end else if (r_run) begin
            r_pp <= r_a[r_i] * r_b[r_j];
            r_sh <= r_i + 3'(r_j);
            if (r_i == r_a_last) begin
                r_i <= 3'd0;
                r_j <= ~r_j;
            end else begin
                r_i <= r_i + 3'd1;
            end
        end
        if (r_pv) begin
            r_acc <= r_acc + pp_shifted;
        end
    end

    assign o_busy = r_run | r_pv;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

>>> rtl/core/sbd_checker.sv
// Port-level checks for the subband energy beat detector, bound to the top level.
// Depends on sbd_pkg and subband_energy_beat_detector.
`default_nettype none

module sbd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input sbd_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sbd_pkg::t_out_item o_out_data
);
    import sbd_pkg::*;

    logic r_seen_ready;
    logic in_req;
    logic out_req;

    assign in_req  = i_in_valid & ~o_in_stall;
    assign out_req = o_out_valid & ~i_out_stall;

    // remembers that a full-history result has gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ready <= 1'b0;
        end else if (out_req && o_out_data.history_ready) begin
            r_seen_ready <= 1'b1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // no beats reported while history fills
    a_mask_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.history_ready |-> o_out_data.beat_mask == '0)
        else $error("beat mask set before history full");

    // history stays full once reported full
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_ready |-> o_out_data.history_ready)
        else $error("history_ready dropped");

    // one bin at a time: a taken request stalls the next cycle
    a_in_serial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req |=> o_in_stall)
        else $error("input taken on consecutive cycles");

endmodule

bind subband_energy_beat_detector sbd_checker u_sbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
